// ===== rtl/core/sdmhl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdmhl_pkg: shared types and constants for the hard location counter bank
// Counter geometry, register indexes and the small helper functions used by
// the write sequencer and the top level.
// ----------------------------------------------------------------------------
package sdmhl_pkg;

  // counter bank geometry
  localparam int unsigned NUM_CTR = 4096;
  localparam int unsigned ADDR_W  = 12;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned SUB_W   = 32;

  // dimension index and full (unclipped) counter address widths
  localparam int unsigned DIM_W   = 18;
  localparam int unsigned FULL_W  = DIM_W + 8;

  // configuration field widths
  localparam int unsigned RANGE_W = 4;
  localparam int unsigned DIMS_W  = 13;
  localparam int unsigned CFG_W   = 13;
  localparam int unsigned IDX_W   = 2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_RANGE = 2'd0;
  localparam logic [IDX_W-1:0] REG_DIMS  = 2'd1;
  localparam logic [IDX_W-1:0] REG_DECR  = 2'd2;

  // opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // counter limits
  localparam logic [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};
  localparam logic [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};

  // settings a write item runs with
  typedef struct packed {
    logic [RANGE_W-1:0] range;
    logic [DIMS_W-1:0]  dims;
    logic               decr;
  } cfg_t;

  // one counter update handed to the bank
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic              up;
  } upd_req_t;

  // clamp range to 1..8
  function automatic logic [RANGE_W-1:0] eff_range(input logic [RANGE_W-1:0] r);
    logic [RANGE_W-1:0] res;
    begin
      if (r == 4'd0) begin
        res = 4'd1;
      end else if (r > 4'd8) begin
        res = 4'd8;
      end else begin
        res = r;
      end
      return res;
    end
  endfunction

  // values per subword for an effective range
  function automatic logic [5:0] values_per_word(input logic [RANGE_W-1:0] r);
    logic [5:0] res;
    begin
      case (r)
        4'd1:    res = 6'd32;
        4'd2:    res = 6'd16;
        4'd3:    res = 6'd10;
        4'd4:    res = 6'd8;
        4'd5:    res = 6'd6;
        4'd6:    res = 6'd5;
        4'd7:    res = 6'd4;
        4'd8:    res = 6'd4;
        default: res = 6'd32;
      endcase
      return res;
    end
  endfunction

  // bit reversal of a subword
  function automatic logic [SUB_W-1:0] bit_rev(input logic [SUB_W-1:0] w);
    logic [SUB_W-1:0] res;
    begin
      for (int i = 0; i < SUB_W; i++) begin
        res[i] = w[SUB_W-1-i];
      end
      return res;
    end
  endfunction

endpackage

// ===== rtl/core/sdm_hard_location_counters.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdm_hard_location_counters: counter bank of one sparse distributed memory
// hard location
// Signed saturating counters in one memory, updated by data subword writes
// and summed into an accumulator (or, in binary mode, voted into it by their sign) by counter reads.
// ----------------------------------------------------------------------------
// After reset the block clears its 4096 counters, one per cycle, and holds
// busy while it does so; configuration writes are taken throughout.
// Every counter update is a read and a write-back on the single counter
// memory, one update per cycle. A write item makes one update per value in
// binary mode and with plain increments, and 2^range_bits updates per value
// in decrement mode; busy stays high until its last write-back is done.
// Updates stop early at data_dims. A read item registers its counter and
// then its result; the result appears on acc_out_o and the other result
// ports for one cycle with out_strobe_o, and a new item may start in that
// same cycle. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module sdm_hard_location_counters (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  logic                                opcode_i,
  input  logic [sdmhl_pkg::ADDR_W-1:0]        position_i,
  input  logic [sdmhl_pkg::SUB_W-1:0]         data_word_i,
  input  logic signed [15:0]                  acc_in_i,
  input  logic                                tie_bit_i,
  input  logic                                last_i,
  // result channel
  output logic                                out_strobe_o,
  output logic signed [15:0]                  acc_out_o,
  output logic [sdmhl_pkg::ADDR_W-1:0]        out_position_o,
  output logic [31:0]                         write_total_o,
  output logic                                out_last_o,
  // configuration channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sdmhl_pkg::IDX_W-1:0]         cfg_index_i,
  input  logic [sdmhl_pkg::CFG_W-1:0]         cfg_data_i
);
  import sdmhl_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RD   = 1'b1;

  logic               st_q, st_d;
  cfg_t               cfg_q;
  logic [31:0]        words_q;
  logic               fire;
  logic               wr_fire;
  logic               rd_fire;
  logic               cfg_fire;
  logic [ADDR_W-1:0]  rd_pos_q;
  logic [15:0]        rd_acc_q;
  logic               rd_tie_q;
  logic               rd_last_q;
  logic [15:0]        acc_res;
  logic [15:0]        acc_out_q;
  logic               strobe_q;
  upd_req_t           upd;
  logic               seq_active;
  logic [CNT_W-1:0]   ctr;
  logic               clr_busy;
  logic               pipe_busy;
  logic               vote_up;
  logic [16:0]        sum;

  // handshakes
  assign busy     = clr_busy | seq_active | pipe_busy | (st_q != ST_IDLE);
  assign fire     = start & ~busy;
  assign wr_fire  = fire & (opcode_i == OP_WRITE);
  assign rd_fire  = fire & (opcode_i == OP_READ);
  assign cfg_ready_o = 1'b1;
  assign cfg_fire = cfg_valid_i & cfg_ready_o;

  sdmhl_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (wr_fire),
    .cfg_i       (cfg_q),
    .position_i  (position_i),
    .data_word_i (data_word_i),
    .upd_o       (upd),
    .active_o    (seq_active)
  );

  sdmhl_bank u_bank (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .upd_i       (upd),
    .raddr_i     (position_i),
    .rdata_o     (ctr),
    .clr_busy_o  (clr_busy),
    .pipe_busy_o (pipe_busy)
  );

  // read result: sign vote in binary mode, else sum clipped at the top, and at the bottom only in decrement mode
  always_comb begin
    vote_up = (!ctr[CNT_W-1] && (ctr != '0)) || ((ctr == '0) && rd_tie_q);
    sum     = {rd_acc_q[15], rd_acc_q} + {ctr[CNT_W-1], ctr};
    acc_res = sum[15:0];
    if (eff_range(cfg_q.range) == 4'd1) begin
      acc_res = rd_acc_q;
      if (vote_up) begin
        if (rd_acc_q != 16'h7fff) begin
          acc_res = rd_acc_q + 1'b1;
        end
      end else begin
        if (rd_acc_q != 16'h8000) begin
          acc_res = rd_acc_q - 1'b1;
        end
      end
    end else if (!sum[16] && sum[15]) begin
      acc_res = 16'h7fff;
    end else if (cfg_q.decr && sum[16] && !sum[15]) begin
      acc_res = 16'h8000;
    end
  end

  // read state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (rd_fire) begin
          st_d = ST_RD;
        end
      end
      ST_RD:   st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  // read item and result payload
  always_ff @(posedge clk_i) begin
    if (rd_fire) begin
      rd_pos_q  <= position_i;
      rd_acc_q  <= acc_in_i;
      rd_tie_q  <= tie_bit_i;
      rd_last_q <= last_i;
    end
    if (st_q == ST_RD) begin
      acc_out_q <= acc_res;
    end
  end

  // control state, registers and word count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      strobe_q    <= 1'b0;
      words_q     <= '0;
      cfg_q.range <= 4'd1;
      cfg_q.dims  <= 13'd256;
      cfg_q.decr  <= 1'b1;
    end else begin
      st_q     <= st_d;
      strobe_q <= (st_q == ST_RD);
      if (wr_fire && last_i && (words_q != 32'hffff_ffff)) begin
        words_q <= words_q + 1'b1;
      end
      if (cfg_fire) begin
        case (cfg_index_i)
          REG_RANGE: cfg_q.range <= cfg_data_i[RANGE_W-1:0];
          REG_DIMS:  cfg_q.dims  <= cfg_data_i[DIMS_W-1:0];
          REG_DECR:  cfg_q.decr  <= cfg_data_i[0];
          default:   ;
        endcase
      end
    end
  end

  assign out_strobe_o   = strobe_q;
  assign acc_out_o      = acc_out_q;
  assign out_position_o = rd_pos_q;
  assign write_total_o  = words_q;
  assign out_last_o     = rd_last_q;

endmodule

// ===== rtl/core/sdmhl_bank.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdmhl_bank: counter memory with read-modify-write update pipe
// Single-port-write, one-read memory of signed counters. An update request
// reads its counter, the next cycle writes it back one step up or down with
// saturation. After reset a clearing pass zeroes every entry.
// ----------------------------------------------------------------------------
module sdmhl_bank (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sdmhl_pkg::upd_req_t       upd_i,
  input  logic [sdmhl_pkg::ADDR_W-1:0] raddr_i,
  output logic [sdmhl_pkg::CNT_W-1:0]  rdata_o,
  output logic                      clr_busy_o,
  output logic                      pipe_busy_o
);
  import sdmhl_pkg::*;

  logic [CNT_W-1:0]  mem [NUM_CTR];
  logic [CNT_W-1:0]  rdata_q;
  logic              clr_q, clr_d;
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;
  logic              pv_q;
  logic [ADDR_W-1:0] pa_q;
  logic              pu_q;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [CNT_W-1:0]  wdata;
  logic [CNT_W-1:0]  bumped;
  logic [ADDR_W-1:0] raddr;

  // clearing pass walks every entry once
  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == ADDR_W'(NUM_CTR - 1)) begin
        clr_d = 1'b0;
      end
    end
  end

  // saturating one-step update of the counter read last cycle
  always_comb begin
    bumped = rdata_q;
    if (pu_q) begin
      if (rdata_q != CNT_MAX) begin
        bumped = rdata_q + 1'b1;
      end
    end else begin
      if (rdata_q != CNT_MIN) begin
        bumped = rdata_q - 1'b1;
      end
    end
  end

  // write port: clear pass or write-back
  always_comb begin
    we    = clr_q | pv_q;
    waddr = clr_q ? clr_addr_q : pa_q;
    wdata = clr_q ? '0 : bumped;
    raddr = upd_i.valid ? upd_i.addr : raddr_i;
  end

  // memory
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // update pipe payload
  always_ff @(posedge clk_i) begin
    pa_q <= upd_i.addr;
    pu_q <= upd_i.up;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      pv_q       <= 1'b0;
    end else begin
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
      pv_q       <= upd_i.valid;
    end
  end

  assign rdata_o     = rdata_q;
  assign clr_busy_o  = clr_q;
  assign pipe_busy_o = pv_q;

endmodule

// ===== rtl/core/sdmhl_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdmhl_seq: write sequencer
// Walks the values of one data subword and issues one counter update per
// cycle: one per bit in binary mode, one per value with plain increments, or
// one per counter of a value group in decrement mode.
// ----------------------------------------------------------------------------
module sdmhl_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  sdmhl_pkg::cfg_t              cfg_i,
  input  logic [sdmhl_pkg::ADDR_W-1:0] position_i,
  input  logic [sdmhl_pkg::SUB_W-1:0]  data_word_i,
  output sdmhl_pkg::upd_req_t          upd_o,
  output logic                         active_o
);
  import sdmhl_pkg::*;

  logic                 active_q, active_d;
  logic [RANGE_W-1:0]   r_q;
  logic [DIMS_W-1:0]    dims_q;
  logic                 decr_q;
  logic [5:0]           per_q;
  logic [5:0]           j_q, j_d;
  logic [7:0]           k_q, k_d;
  logic [DIM_W-1:0]     dim_q, dim_d;
  logic [SUB_W-1:0]     data_q, data_d;
  logic                 done;
  logic                 binary;
  logic                 group;
  logic [7:0]           val;
  logic [7:0]           mask;
  logic                 last_k;
  logic [FULL_W-1:0]    addr_full;
  logic [5:0]           per_in;
  logic [RANGE_W-1:0]   r_in;

  assign r_in   = eff_range(cfg_i.range);
  assign per_in = values_per_word(r_in);

  // current value and address
  always_comb begin
    binary = (r_q == 4'd1);
    group  = !binary && decr_q;
    done   = (j_q == per_q) || (dim_q >= DIM_W'(dims_q));
    val    = data_q[SUB_W-1 -: 8] >> (4'd8 - r_q);
    mask   = 8'((9'd1 << r_q) - 9'd1);
    last_k = !group || (k_q == mask);
    if (binary) begin
      addr_full = FULL_W'(dim_q);
    end else begin
      addr_full = (FULL_W'(dim_q) << r_q) | FULL_W'(group ? k_q : val);
    end
    upd_o.valid = active_q && !done && (addr_full[FULL_W-1:ADDR_W] == '0);
    upd_o.addr  = addr_full[ADDR_W-1:0];
    if (binary) begin
      upd_o.up = val[0];
    end else begin
      upd_o.up = group ? (k_q == val) : 1'b1;
    end
  end

  // step to the next counter
  always_comb begin
    active_d = active_q;
    j_d      = j_q;
    k_d      = k_q;
    dim_d    = dim_q;
    data_d   = data_q;
    if (load_i) begin
      active_d = 1'b1;
      j_d      = '0;
      k_d      = '0;
      dim_d    = DIM_W'(position_i * per_in);
      data_d   = (r_in == 4'd1) ? bit_rev(data_word_i) : data_word_i;
    end else if (active_q) begin
      if (done) begin
        active_d = 1'b0;
      end else if (last_k) begin
        k_d    = '0;
        j_d    = j_q + 1'b1;
        dim_d  = dim_q + 1'b1;
        data_d = data_q << r_q;
      end else begin
        k_d = k_q + 1'b1;
      end
    end
  end

  // item settings and walk payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      r_q    <= r_in;
      dims_q <= cfg_i.dims;
      decr_q <= cfg_i.decr;
      per_q  <= per_in;
    end
    j_q    <= j_d;
    k_q    <= k_d;
    dim_q  <= dim_d;
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= active_d;
    end
  end

  assign active_o = active_q;

endmodule

// ===== sim/sdm_counter_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdm_counter_check: predicts and checks the hard location counter bank
// Keeps its own copy of the counters, the word count and the register
// settings, applies every accepted command word and register write, and
// compares each result strobe, field by field, with the oldest read reply
// still waiting.
// ----------------------------------------------------------------------------
module sdm_counter_check
  import sdmhl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // command channel
  input  logic                start_i,
  input  logic                busy_i,
  input  logic                opcode_i,
  input  logic [ADDR_W-1:0]   position_i,
  input  logic [SUB_W-1:0]    data_word_i,
  input  logic signed [15:0]  acc_in_i,
  input  logic                tie_bit_i,
  input  logic                last_i,
  // result channel
  input  logic                out_strobe_i,
  input  logic signed [15:0]  acc_out_i,
  input  logic [ADDR_W-1:0]   out_position_i,
  input  logic [31:0]         write_total_i,
  input  logic                out_last_i,
  // configuration channel
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  // status for the stimulus side
  output int                  fail_count_o,
  output int                  pending_o
);

  localparam int ACC_TOP    = 32767;
  localparam int ACC_BOTTOM = -32768;

  // one predicted read reply
  typedef struct packed {
    logic signed [15:0] acc;
    logic [ADDR_W-1:0]  position;
    logic [31:0]        total;
    logic               last;
  } read_reply_t;

  read_reply_t             replies_q[$];
  logic signed [CNT_W-1:0] counters [NUM_CTR];
  logic [31:0]             words_done;
  logic [RANGE_W-1:0]      range_set;
  logic [DIMS_W-1:0]       dims_set;
  logic                    decr_set;
  int                      fails;

  // range register with out-of-bounds values folded to 1..8
  function automatic int unsigned value_bits();
    if (range_set == '0) return 1;
    if (range_set > 4'd8) return 8;
    return range_set;
  endfunction

  // saturating step of one counter, indexes past the bank are dropped
  function automatic void step_counter(input int unsigned idx, input logic up);
    if (idx < NUM_CTR) begin
      if (up) begin
        if (counters[idx] != CNT_MAX) counters[idx] = counters[idx] + 1'b1;
      end else begin
        if (counters[idx] != CNT_MIN) counters[idx] = counters[idx] - 1'b1;
      end
    end
  endfunction

  // counter updates caused by one data subword
  function automatic void apply_subword(input logic [ADDR_W-1:0] pos,
                                        input logic [SUB_W-1:0] data);
    int unsigned r, per, span, dim, val, base;
    r = value_bits();
    if (r == 1) begin
      // binary: one counter per bit, lsb first
      for (int unsigned j = 0; j < SUB_W; j++) begin
        dim = pos * SUB_W + j;
        if (dim < dims_set) step_counter(dim, data[j]);
      end
    end else begin
      // one-hot: values taken msb first
      per  = SUB_W / r;
      span = 1 << r;
      for (int unsigned j = 0; j < per; j++) begin
        dim  = pos * per + j;
        val  = (data >> (SUB_W - (j + 1) * r)) & (span - 1);
        base = dim * span;
        if (dim < dims_set) begin
          if (decr_set) begin
            for (int unsigned k = 0; k < span; k++) step_counter(base + k, k == val);
          end else begin
            step_counter(base + val, 1'b1);
          end
        end
      end
    end
  endfunction

  // accumulator after adding one counter
  function automatic logic [15:0] accumulate(input logic [ADDR_W-1:0] pos,
                                             input logic signed [15:0] acc,
                                             input logic tie);
    int c, a, s;
    c = counters[pos];
    a = acc;
    if (value_bits() == 1) begin
      // sign vote, zero counters follow the tie bit
      if (c > 0 || (c == 0 && tie)) begin
        s = (a < ACC_TOP) ? a + 1 : a;
      end else begin
        s = (a > ACC_BOTTOM) ? a - 1 : a;
      end
    end else begin
      s = a + c;
      if (s > ACC_TOP) begin
        s = ACC_TOP;
      end else if (decr_set && s < ACC_BOTTOM) begin
        s = ACC_BOTTOM;
      end
    end
    return s[15:0];
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    read_reply_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CTR; i++) counters[i] = '0;
      words_done = '0;
      range_set  = 4'd1;
      dims_set   = 13'd256;
      decr_set   = 1'b1;
      fails      = 0;
      replies_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // results belong to earlier words, so they go first
      if (out_strobe_i) begin
        if (replies_q.size() == 0) begin
          $display("%0t: result with no read waiting: expected none, actual acc %0h pos %0h",
                   $time, acc_out_i, out_position_i);
          fails++;
        end else begin
          want = replies_q.pop_front();
          compare_field("acc_out", 32'(want.acc), 32'(acc_out_i));
          compare_field("out_position", 32'(want.position), 32'(out_position_i));
          compare_field("write_total", want.total, write_total_i);
          compare_field("out_last", 32'(want.last), 32'(out_last_i));
        end
      end

      // register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_RANGE: range_set = cfg_data_i[RANGE_W-1:0];
          REG_DIMS:  dims_set  = cfg_data_i[DIMS_W-1:0];
          REG_DECR:  decr_set  = cfg_data_i[0];
          default: ;
        endcase
      end

      // accepted command word
      if (start_i && !busy_i) begin
        if (opcode_i == OP_WRITE) begin
          apply_subword(position_i, data_word_i);
          if (last_i && words_done != '1) words_done = words_done + 1'b1;
        end else begin
          want = '{accumulate(position_i, acc_in_i, tie_bit_i),
                   position_i, words_done, last_i};
          replies_q.insert(replies_q.size(), want);
        end
      end

      fail_count_o <= fails;
      pending_o    <= replies_q.size();
    end
  end

endmodule

// ===== sim/sdm_hard_location_counters_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdm_hard_location_counters_test: regression for the hard location counters
// Drives directed corner words, a run of repeated writes to one value group
// and random phases over many register settings with varied sender idling;
// the checker beside the block predicts every read reply and counts
// mismatches.
// ----------------------------------------------------------------------------
module sdm_hard_location_counters_test;
  import sdmhl_pkg::*;

  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES   = 1100;
  localparam int CYCLE_LIMIT     = 3000000;
  localparam int REPEAT_WRITES   = 100;

  logic                clk_i;
  logic                rst_ni     = 1'b0;
  logic                start      = 1'b0;
  logic                busy;
  logic                opcode     = OP_WRITE;
  logic [ADDR_W-1:0]   position   = '0;
  logic [SUB_W-1:0]    data_word  = '0;
  logic signed [15:0]  acc_in     = '0;
  logic                tie_bit    = 1'b0;
  logic                last       = 1'b0;
  logic                out_strobe;
  logic signed [15:0]  acc_out;
  logic [ADDR_W-1:0]   out_position;
  logic [31:0]         write_total;
  logic                out_last;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic [IDX_W-1:0]    cfg_index  = REG_RANGE;
  logic [CFG_W-1:0]    cfg_data   = '0;
  int                  fail_count;
  int                  pending;
  int                  cycle_count = 0;

  sdm_hard_location_counters i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode),
    .position_i     (position),
    .data_word_i    (data_word),
    .acc_in_i       (acc_in),
    .tie_bit_i      (tie_bit),
    .last_i         (last),
    .out_strobe_o   (out_strobe),
    .acc_out_o      (acc_out),
    .out_position_o (out_position),
    .write_total_o  (write_total),
    .out_last_o     (out_last),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  sdm_counter_check u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .opcode_i       (opcode),
    .position_i     (position),
    .data_word_i    (data_word),
    .acc_in_i       (acc_in),
    .tie_bit_i      (tie_bit),
    .last_i         (last),
    .out_strobe_i   (out_strobe),
    .acc_out_i      (acc_out),
    .out_position_i (out_position),
    .write_total_i  (write_total),
    .out_last_i     (out_last),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run time guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // present one command word and hold it until the block takes it
  task automatic push_word(input logic op, input logic [ADDR_W-1:0] pos,
                           input logic [SUB_W-1:0] data, input logic [15:0] acc,
                           input logic tie, input logic fin);
    start     <= 1'b1;
    opcode    <= op;
    position  <= pos;
    data_word <= data;
    acc_in    <= acc;
    tie_bit   <= tie;
    last      <= fin;
    do @(posedge clk_i); while (busy);
  endtask

  // random sender gap, now and then a long one
  task automatic idle_gap(input int pct);
    int len;
    if ($urandom_range(99) < pct) begin
      len = ($urandom_range(19) == 0) ? $urandom_range(13, 120) : $urandom_range(1, 12);
      start <= 1'b0;
      repeat (len) @(posedge clk_i);
    end
  endtask

  // hold off until every read reply is back
  task automatic wait_replies();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // block fully idle, writes with no reply included
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0 || busy);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // one register write, valid stays up for the caller
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  task automatic program_regs(input logic [RANGE_W-1:0] rng, input logic [DIMS_W-1:0] dims,
                              input logic decr);
    write_reg(REG_RANGE, CFG_W'(rng));
    write_reg(REG_DIMS, CFG_W'(dims));
    write_reg(REG_DECR, CFG_W'(decr));
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // corner words, then repeated writes to one value group
  task automatic run_directed();
    // binary mode at reset settings
    push_word(OP_WRITE, 12'd0, 32'hffff_ffff, 16'h0000, 1'b0, 1'b0);
    push_word(OP_WRITE, 12'd0, 32'h0000_0000, 16'h0000, 1'b0, 1'b1);
    push_word(OP_WRITE, 12'd7, 32'ha5a5_5a5a, 16'h0000, 1'b0, 1'b1);
    push_word(OP_WRITE, 12'd8, 32'hffff_ffff, 16'h0000, 1'b0, 1'b0);
    push_word(OP_WRITE, 12'd4095, 32'h1234_5678, 16'h0000, 1'b0, 1'b1);
    push_word(OP_READ, 12'd0, 32'h0, 16'h7fff, 1'b1, 1'b0);
    push_word(OP_READ, 12'd0, 32'h0, 16'h8000, 1'b0, 1'b0);
    push_word(OP_READ, 12'd225, 32'h0, 16'h0000, 1'b0, 1'b0);
    push_word(OP_READ, 12'd224, 32'h0, 16'd100, 1'b1, 1'b0);
    push_word(OP_READ, 12'd4095, 32'h0, 16'hffff, 1'b1, 1'b1);

    // widest values with decrement of the others
    settle();
    program_regs(4'd8, 13'd8191, 1'b1);
    push_word(OP_WRITE, 12'd0, 32'hff00_8001, 16'h0000, 1'b0, 1'b1);
    push_word(OP_READ, 12'd255, 32'h0, 16'h7fff, 1'b0, 1'b0);
    push_word(OP_READ, 12'd256, 32'h0, 16'hfffb, 1'b0, 1'b0);
    push_word(OP_READ, 12'd300, 32'h0, 16'h8000, 1'b0, 1'b1);

    // range above 8, plain increments, low sum wraps
    settle();
    program_regs(4'd15, 13'd8191, 1'b0);
    push_word(OP_READ, 12'd300, 32'h0, 16'h8000, 1'b0, 1'b0);
    push_word(OP_WRITE, 12'd1, 32'h0102_0304, 16'h0000, 1'b0, 1'b0);

    // range zero acts as binary, no dimensions in use
    settle();
    program_regs(4'd0, 13'd0, 1'b1);
    write_reg(REG_SPARE, 13'h1fff);
    cfg_valid <= 1'b0;
    push_word(OP_WRITE, 12'd0, 32'hffff_ffff, 16'h0000, 1'b0, 1'b1);
    push_word(OP_READ, 12'd1, 32'h0, 16'h0000, 1'b0, 1'b0);

    // one dimension, value 0 over and over: counter 0 climbs, 1..3 fall
    settle();
    program_regs(4'd2, 13'd1, 1'b1);
    for (int n = 0; n < REPEAT_WRITES; n++) begin
      push_word(OP_WRITE, 12'd0, 32'h0000_0000, 16'($urandom()),
                1'($urandom_range(1)), 1'b1);
    end
    settle();
    program_regs(4'd2, 13'd1, 1'b0);
    for (int n = 0; n < 3; n++) begin
      push_word(OP_WRITE, 12'd0, 32'h0000_0000, 16'h0000, 1'b0, 1'b0);
    end
    push_word(OP_READ, 12'd0, 32'h0, 16'h0001, 1'b0, 1'b0);
    push_word(OP_READ, 12'd1, 32'h0, 16'hffff, 1'b0, 1'b0);
    push_word(OP_READ, 12'd3, 32'h0, 16'h0000, 1'b0, 1'b1);
  endtask

  // random words under one register setting
  task automatic run_phase(input logic [RANGE_W-1:0] rng, input logic [DIMS_W-1:0] dims,
                           input logic decr, input int idle_pct, input int count,
                           input int write_pct);
    int unsigned r, per, span, word_lim, ctr_lim, hot_words, hot_ctrs, sel;
    logic               op;
    logic [ADDR_W-1:0]  pos;
    logic [SUB_W-1:0]   pattern, data;
    logic [15:0]        acc;
    settle();
    program_regs(rng, dims, decr);
    r    = (rng == 0) ? 1 : ((rng > 8) ? 8 : rng);
    per  = SUB_W / r;
    span = (r == 1) ? 1 : (1 << r);

    // subwords and counters that the setting actually reaches
    word_lim = (dims + per - 1) / per;
    if (word_lim == 0) word_lim = 1;
    if (word_lim > NUM_CTR) word_lim = NUM_CTR;
    ctr_lim = dims * span;
    if (ctr_lim == 0) ctr_lim = 1;
    if (ctr_lim > NUM_CTR) ctr_lim = NUM_CTR;
    hot_words = (word_lim < 8) ? word_lim : 8;
    hot_ctrs  = hot_words * per * span;
    if (hot_ctrs > ctr_lim) hot_ctrs = ctr_lim;
    pattern = $urandom();

    for (int n = 0; n < count; n++) begin
      op  = ($urandom_range(99) < write_pct) ? OP_WRITE : OP_READ;
      sel = $urandom_range(99);
      if (op == OP_WRITE) begin
        if (sel < 60) pos = ADDR_W'($urandom_range(0, hot_words - 1));
        else if (sel < 90) pos = ADDR_W'($urandom_range(0, word_lim - 1));
        else pos = ADDR_W'($urandom_range(0, NUM_CTR - 1));
      end else begin
        if (sel < 70) pos = ADDR_W'($urandom_range(0, hot_ctrs - 1));
        else if (sel < 90) pos = ADDR_W'($urandom_range(0, ctr_lim - 1));
        else pos = ADDR_W'($urandom_range(0, NUM_CTR - 1));
      end

      // repeated patterns push counters far from zero
      sel = $urandom_range(99);
      if (sel < 25) data = pattern;
      else if (sel < 40) data = pattern ^ (32'd1 << $urandom_range(31));
      else if (sel < 45) data = sel[0] ? '1 : '0;
      else data = $urandom();

      sel = $urandom_range(99);
      if (sel < 10) acc = 16'h7fff - 16'($urandom_range(3));
      else if (sel < 20) acc = 16'h8000 + 16'($urandom_range(3));
      else if (sel < 30) acc = 16'($urandom_range(8)) - 16'd4;
      else acc = 16'($urandom());

      push_word(op, pos, data, acc, 1'($urandom_range(1)), $urandom_range(3) == 0);
      if (n == count / 2) wait_replies();
      else idle_gap(idle_pct);
    end
  endtask

  // stimulus and verdict
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // reset values written back while the bank clears
    program_regs(4'd1, 13'd256, 1'b1);
    run_directed();

    run_phase(4'd1, 13'd4096, 1'b1, 0, 300, 50);
    run_phase(4'd2, 13'd300, 1'b0, 74, 250, 50);
    run_phase(4'd3, 13'd1000, 1'b1, 36, 250, 50);
    run_phase(4'd0, 13'd8191, 1'b0, 0, 250, 50);
    run_phase(4'd8, 13'd8191, 1'b1, 74, 60, 25);
    run_phase(4'd15, 13'd64, 1'b0, 36, 200, 50);
    run_phase(4'd5, 13'd1, 1'b1, 0, 150, 50);
    run_phase(4'd4, 13'd2048, 1'b0, 74, 200, 50);
    run_phase(4'd7, 13'd0, 1'b1, 36, 100, 50);
    run_phase(4'd6, 13'd600, 1'b1, 0, 140, 50);

    // drain and let any late strobe show up
    settle();
    @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
